/* rtl/sobel_pkg.sv */
// shared types and constants of the sobel edge and focus score block
`default_nettype none

package sobel_pkg;

    // field and register widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int ROW_W     = 12;
    localparam int EDGE_W    = 8;
    localparam int SCORE_W   = 19;
    localparam int ENERGY_W  = 48;
    localparam int GRAD_W    = 12;
    localparam int SQ_W      = 21;
    localparam int WH_W      = 26;
    localparam int DIVISOR_W = 29;

    // frame geometry
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 3;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // edge saturation limit
    localparam logic [EDGE_W-1:0] EDGE_MAX = 8'd255;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // per-pixel sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SQUARE,
        ST_ACCUM,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    // divider handshake with the sequencer
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/sobel_ram.sv */
// generic single-clock ram with one write port and one registered read port
`default_nettype none

module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sobel_div.sv */
// restoring divider, one quotient bit per cycle, for the frame focus score
`default_nettype none

module sobel_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sobel_pkg::div_req_t               req,
    input  wire logic [sobel_pkg::ENERGY_W-1:0]    dividend,
    input  wire logic [sobel_pkg::DIVISOR_W-1:0]   divisor,
    output sobel_pkg::div_rsp_t                    rsp,
    output logic      [sobel_pkg::SCORE_W-1:0]     quotient
);

    import sobel_pkg::*;

    localparam int CNT_W = $clog2(ENERGY_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ENERGY_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [ENERGY_W-1:0]  quo_reg;
    logic [DIVISOR_W-1:0] dsr_reg;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 qbit;

    // trial subtract of the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[ENERGY_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        qbit    = ~diff[DIVISOR_W];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[ENERGY_W-2:0], qbit};
        end
    end

    assign rsp.done = done_reg;
    assign quotient = quo_reg[SCORE_W-1:0];

endmodule

`default_nettype wire

/* rtl/sobel_edge_magnitude_with_focus_score.sv */
// sobel 3x3 edge magnitude with frame focus score, top level
//
// usage: pixels of a frame arrive in raster order on in_valid/in_ready/pixel.
// frame_width and frame_height are written through cfg_write/cfg_index/
// cfg_data while the block is idle; width is clamped to 3..MAX_WIDTH and
// height to 3..4096. every interior pixel gives one beat on out_valid/
// out_ready with edge_value = min(|gx|+|gy|, 255). the beat for the last
// interior pixel has frame_last set and focus_score = energy / (w*h*5);
// all other beats carry a zero score. border pixels give no beat.
// throughput: one pixel at a time. a border pixel takes only the read and
// write-back of the single line store memory; an interior pixel runs line
// store read, gradient, square, accumulate and emit steps in turn.
// the last pixel of a frame adds the multiply and the bit-per-cycle divider.
// the output register holds a finished beat while the receiver stalls; a
// new pixel may still be accepted, its result waits in the emit step.
// reset clears counters, window and energy; line store contents stay
// undefined and need no clearing pass.
`default_nettype none

module sobel_edge_magnitude_with_focus_score #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic                            cfg_index,
    input  wire logic [sobel_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [sobel_pkg::PIX_W-1:0]     pixel,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [sobel_pkg::EDGE_W-1:0]    edge_value,
    output logic                                 frame_last,
    output logic      [sobel_pkg::SCORE_W-1:0]   focus_score
);

    import sobel_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int LS_W  = 2 * PIX_W;

    // configuration and sequencer
    logic [CFG_W-1:0]    frame_width_reg;
    logic [CFG_W-1:0]    frame_height_reg;
    state_t              state_reg;
    state_t              state_next;

    // position and window
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [PIX_W-1:0]    win_reg [6];
    logic [PIX_W-1:0]    pix_reg;

    // result datapath
    logic signed [10:0]  gx_reg;
    logic signed [10:0]  gy_reg;
    logic [EDGE_W-1:0]   edge_reg;
    logic                fin_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [WH_W-1:0]     wh_reg;
    logic [SCORE_W-1:0]  score_reg;

    // output register
    logic                out_valid_reg;
    logic [EDGE_W-1:0]   edge_out_reg;
    logic                last_out_reg;
    logic [SCORE_W-1:0]  score_out_reg;

    // combinational helpers
    logic [CFG_W-1:0]    w_use;
    logic [CFG_W-1:0]    h_use;
    logic                accept;
    logic                last_col;
    logic                last_row;
    logic                interior;
    logic [LS_W-1:0]     ls_rdata;
    logic [PIX_W-1:0]    top;
    logic [PIX_W-1:0]    mid;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [GRAD_W-1:0]   abs_sum;
    logic signed [21:0]  gx_sq;
    logic signed [21:0]  gy_sq;
    logic [WH_W-1:0]     wh;
    logic [DIVISOR_W-1:0] divisor;
    logic                out_free;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic [SCORE_W-1:0]  div_quotient;

    // clamped frame geometry
    always_comb
    begin
        if (frame_width_reg < CFG_W'(MIN_DIM))
        begin
            w_use = CFG_W'(MIN_DIM);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_use = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            w_use = frame_width_reg;
        end

        if (frame_height_reg < CFG_W'(MIN_DIM))
        begin
            h_use = CFG_W'(MIN_DIM);
        end
        else if (frame_height_reg > CFG_W'(MAX_HEIGHT))
        begin
            h_use = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_use = frame_height_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // line store: upper row in the high byte, middle row in the low byte
    sobel_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (state_reg == ST_CALC),
        .waddr (col_reg),
        .wdata ({mid, pix_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ls_rdata)
    );

    assign top = ls_rdata[LS_W-1:PIX_W];
    assign mid = ls_rdata[PIX_W-1:0];

    // position flags of the current pixel
    always_comb
    begin
        last_col = (32'(col_reg) + 32'd1) >= 32'(w_use);
        last_row = (32'(row_reg) + 32'd1) >= 32'(h_use);
        interior = (32'(row_reg) >= 32'd2) && (32'(col_reg) >= 32'd2);
    end

    // sobel gradients over the window and the new column
    always_comb
    begin
        gx = $signed({4'b0, win_reg[0]}) + $signed({3'b0, win_reg[1], 1'b0})
           + $signed({4'b0, win_reg[2]}) - $signed({4'b0, top})
           - $signed({3'b0, mid, 1'b0}) - $signed({4'b0, pix_reg});
        gy = $signed({4'b0, win_reg[0]}) + $signed({3'b0, win_reg[3], 1'b0})
           + $signed({4'b0, top}) - $signed({4'b0, win_reg[2]})
           - $signed({3'b0, win_reg[5], 1'b0}) - $signed({4'b0, pix_reg});
        abs_sum = (gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx))
                + (gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy));
    end

    // squares, product of the frame size and the score divisor
    always_comb
    begin
        gx_sq   = gx_reg * gx_reg;
        gy_sq   = gy_reg * gy_reg;
        wh      = w_use * h_use;
        divisor = {1'b0, wh_reg, 2'b00} + {3'b000, wh_reg};
    end

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and handshake outputs
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        div_req.start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = interior ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = fin_reg ? ST_MUL : ST_EMIT;
            end
            ST_MUL:
            begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // counters, window and energy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            energy_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_CALC)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= pix_reg;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (state_reg == ST_ACCUM)
            begin
                energy_reg <= energy_reg + ENERGY_W'(sq_reg);
            end
            else if (state_reg == ST_DIV_START)
            begin
                energy_reg <= '0;
            end
        end
    end

    // per-pixel datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pixel;
        end
        if (state_reg == ST_CALC)
        begin
            gx_reg   <= 11'(gx);
            gy_reg   <= 11'(gy);
            edge_reg <= (abs_sum > GRAD_W'(EDGE_MAX)) ? EDGE_MAX : EDGE_W'(abs_sum);
            fin_reg  <= last_col && last_row;
        end
        if (state_reg == ST_SQUARE)
        begin
            sq_reg <= {1'b0, gx_sq[19:0]} + {1'b0, gy_sq[19:0]};
        end
        if (state_reg == ST_ACCUM)
        begin
            score_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            wh_reg <= wh;
        end
        if (state_reg == ST_DIV_WAIT && div_rsp.done)
        begin
            score_reg <= div_quotient;
        end
    end

    // focus score divider
    sobel_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (energy_reg),
        .divisor  (divisor),
        .rsp      (div_rsp),
        .quotient (div_quotient)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            edge_out_reg  <= edge_reg;
            last_out_reg  <= fin_reg;
            score_out_reg <= score_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign edge_value  = edge_out_reg;
    assign frame_last  = last_out_reg;
    assign focus_score = score_out_reg;

    // checks
    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CALC)
        else $error("accepted pixel did not move to the gradient step");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the wait step");

    a_score_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_last |-> focus_score == '0)
        else $error("nonzero focus score on a beat that is not frame last");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < MAX_WIDTH)
        else $error("column counter beyond line store depth");

endmodule

`default_nettype wire
